[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the slice set builder
// Clocked property checks on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define ASSERT_HOLDS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never comes true out of reset
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(name, prop, msg)
`define ASSERT_NEVER(name, cond, msg)
`endif

`endif

[design/sssb_pkg.sv]
// ----------------------------------------------------------------------------
// sssb_pkg
// Shared constants of the sliced ELLPACK slice set builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sssb_pkg;

    // Field widths
    localparam int ELEM_W = 64;
    localparam int CFG_W  = 9;
    localparam int NUM_W  = 16;
    localparam int LEN_W  = 13;
    localparam int OFS_W  = 32;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_ROWS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_STRIDE = 1'b1;
    localparam logic [CFG_W-1:0] SLICE_ROWS_RESET   = 9'd64;
    localparam logic [CFG_W-1:0] ROUND_STRIDE_RESET = 9'd1;

    // Largest stride honored
    localparam int STRIDE_MAX = 256;

    // Defaults of the top level parameters
    localparam int DEF_MAX_COLUMNS    = 4096;
    localparam int DEF_MAX_SLICE_ROWS = 256;
    localparam int DEF_ROW_QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

[design/sssb_front.sv]
// ----------------------------------------------------------------------------
// sssb_front
// Takes element words, tests each for nonzero and counts per row; pushes one
// row record (count, matrix end) to the row queue at each row end or matrix end.
// ----------------------------------------------------------------------------
`default_nettype none

module sssb_front
    import sssb_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [ELEM_W-1:0]                   element_bits,
    input  wire logic                                row_end,
    input  wire logic                                matrix_end,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output logic [$clog2(MAX_COLUMNS+1):0]           q_data
);

    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;
    logic             accept;
    logic             nonzero;
    logic             closes_row;

    // Hold input while the queue cannot take a row record
    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;

    // Sign bit ignored so negative zero counts as zero
    assign nonzero    = |element_bits[ELEM_W-2:0];
    assign closes_row = row_end || matrix_end;

    // Saturating row count including this word
    always_comb
    begin
        cnt_inc = cnt_reg;
        if (nonzero && (cnt_reg < CNT_W'(MAX_COLUMNS)))
        begin
            cnt_inc = cnt_reg + CNT_W'(1);
        end
    end

    // Advance count; drop it at a row end
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = closes_row ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Push the finished row
    assign q_push = accept && closes_row;
    assign q_data = {matrix_end, cnt_inc};

endmodule

`default_nettype wire

[design/sssb_queue.sv]
// ----------------------------------------------------------------------------
// sssb_queue
// Small FIFO of row records between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sssb_queue
    import sssb_pkg::*;
#(
    parameter int WIDTH = 14,
    parameter int DEPTH = DEF_ROW_QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed record
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_queue_overflow, push && full && !pop, "row queue overflow")
    `ASSERT_NEVER(a_queue_underflow, pop && empty, "row queue underflow")

endmodule

`default_nettype wire

[design/sssb_back.sv]
// ----------------------------------------------------------------------------
// sssb_back
// Pops row records, rounds each count up to the stride with a bit-serial
// remainder unit, tracks the slice peak and emits slice words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sssb_back
    import sssb_pkg::*;
#(
    parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS,
    parameter int MAX_SLICE_ROWS = DEF_MAX_SLICE_ROWS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [CFG_W-1:0]                  slice_rows,
    input  wire logic [CFG_W-1:0]                  round_stride,
    input  wire logic                              q_empty,
    input  wire logic [$clog2(MAX_COLUMNS+1):0]    q_data,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [NUM_W-1:0]                       slice_number,
    output logic [LEN_W-1:0]                       slice_length,
    output logic [OFS_W-1:0]                       slice_start,
    output logic [OFS_W-1:0]                       slice_end,
    output logic                                   last_slice
);

    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int BIT_W  = (CNT_W > 1) ? $clog2(CNT_W) : 1;
    localparam int RND_W  = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam int PK_W   = (RND_W > LEN_W) ? RND_W : LEN_W;
    localparam int SR_MAX = (MAX_SLICE_ROWS < 511) ? MAX_SLICE_ROWS : 511;
    localparam int RW     = $clog2(SR_MAX + 1);
    localparam int REM_W  = 8;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ACCUM = 5'b01000,
        ST_EMIT  = 5'b10000
    } back_state_t;

    back_state_t      state_reg;
    back_state_t      state_next;

    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic             mat_reg;
    logic             mat_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [RND_W-1:0] rounded_reg;
    logic [RND_W-1:0] rounded_next;

    logic [PK_W-1:0]  peak_reg;
    logic [PK_W-1:0]  peak_next;
    logic [RW-1:0]    rows_reg;
    logic [RW-1:0]    rows_next;
    logic [OFS_W-1:0] offset_reg;
    logic [OFS_W-1:0] offset_next;
    logic [NUM_W-1:0] counter_reg;
    logic [NUM_W-1:0] counter_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [NUM_W-1:0] number_reg;
    logic [LEN_W-1:0] length_reg;
    logic [OFS_W-1:0] start_reg;
    logic [OFS_W-1:0] end_reg;
    logic             last_reg;

    logic [CFG_W-1:0] stride_eff;
    logic [RW-1:0]    size_eff;
    logic [REM_W:0]   rem_shift;
    logic [PK_W-1:0]  peak_max;
    logic [RW-1:0]    rows_inc;
    logic [OFS_W:0]   end_sum;
    logic [OFS_W-1:0] end_sat;
    logic [LEN_W-1:0] len_val;
    logic             out_load;

    // Clamp configuration to the supported ranges
    always_comb
    begin
        if (round_stride == '0)
        begin
            stride_eff = CFG_W'(1);
        end
        else if (32'(round_stride) > STRIDE_MAX)
        begin
            stride_eff = CFG_W'(STRIDE_MAX);
        end
        else
        begin
            stride_eff = round_stride;
        end

        if (slice_rows == '0)
        begin
            size_eff = RW'(1);
        end
        else if (32'(slice_rows) > MAX_SLICE_ROWS)
        begin
            size_eff = RW'(MAX_SLICE_ROWS);
        end
        else
        begin
            size_eff = RW'(slice_rows);
        end
    end

    // One remainder bit per cycle, restoring form
    assign rem_shift = {rem_reg, n_reg[bit_reg]};

    // Slice peak, row count and saturating end offset
    assign peak_max = (PK_W'(rounded_reg) > peak_reg) ? PK_W'(rounded_reg) : peak_reg;
    assign rows_inc = rows_reg + RW'(1);
    assign len_val  = peak_reg[LEN_W-1:0];
    assign end_sum  = {1'b0, offset_reg} + (OFS_W + 1)'(len_val);
    assign end_sat  = end_sum[OFS_W] ? {OFS_W{1'b1}} : end_sum[OFS_W-1:0];

    // Load the output register when it is empty or being taken
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        mat_next     = mat_reg;
        bit_next     = bit_reg;
        rem_next     = rem_reg;
        rounded_next = rounded_reg;
        peak_next    = peak_reg;
        rows_next    = rows_reg;
        offset_next  = offset_reg;
        counter_next = counter_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Take the next row record
                if (!q_empty)
                begin
                    n_next     = q_data[CNT_W-1:0];
                    mat_next   = q_data[CNT_W];
                    bit_next   = BIT_W'(CNT_W - 1);
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_shift >= (REM_W + 1)'(stride_eff))
                begin
                    rem_next = REM_W'(rem_shift - (REM_W + 1)'(stride_eff));
                end
                else
                begin
                    rem_next = rem_shift[REM_W-1:0];
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_ROUND:
            begin
                // Round up to the next multiple of the stride
                if (rem_reg == '0)
                begin
                    rounded_next = RND_W'(n_reg);
                end
                else
                begin
                    rounded_next = RND_W'(n_reg) + RND_W'(stride_eff) - RND_W'(rem_reg);
                end
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                peak_next = peak_max;
                if ((rows_inc >= size_eff) || mat_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    rows_next  = rows_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // Close the slice; clear everything at the matrix end
                if (out_load)
                begin
                    peak_next  = '0;
                    rows_next  = '0;
                    state_next = ST_IDLE;
                    if (mat_reg)
                    begin
                        offset_next  = '0;
                        counter_next = '0;
                    end
                    else
                    begin
                        offset_next  = end_sat;
                        counter_next = counter_reg + NUM_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the output word until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            peak_reg      <= '0;
            rows_reg      <= '0;
            offset_reg    <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            rows_reg      <= rows_next;
            offset_reg    <= offset_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output payload
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        mat_reg     <= mat_next;
        bit_reg     <= bit_next;
        rem_reg     <= rem_next;
        rounded_reg <= rounded_next;
        if (out_load)
        begin
            number_reg <= counter_reg;
            length_reg <= len_val;
            start_reg  <= offset_reg;
            end_reg    <= end_sat;
            last_reg   <= mat_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slice_number = number_reg;
    assign slice_length = length_reg;
    assign slice_start  = start_reg;
    assign slice_end    = end_reg;
    assign last_slice   = last_reg;

    `ASSERT_HOLDS(a_rem_below_stride, (state_reg == ST_ROUND) |-> (rem_reg < REM_W'(stride_eff - 9'd1) + 9'd1), "remainder not below stride")
    `ASSERT_HOLDS(a_matrix_end_clears, (out_load && mat_reg) |=> (offset_reg == '0 && counter_reg == '0 && rows_reg == '0), "state not cleared after matrix end")

endmodule

`default_nettype wire

[design/sell_slice_set_builder_unit.sv]
// ----------------------------------------------------------------------------
// sell_slice_set_builder_unit
// Builds sliced ELLPACK slice lengths and offsets from a dense matrix stream.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   element_bits, row_end, matrix_end
//  out      output     out_valid / out_stall slice_number, slice_length,
//                                            slice_start, slice_end, last_slice
//  cfg      input      cfg_write             cfg_index, cfg_data
//
//  The front takes one element word per cycle; in_stall rises only while the
//  row queue (ROW_QUEUE_DEPTH records) is full.
//  The back works each row record through the bit-serial stride remainder,
//  rounding and accumulation before it pops the next record, and closes each
//  slice in a separate emit state.
//  A stalled output word holds in its register while the back keeps rounding.
//  Reset clears all counters; the slice row count resets to 64, the stride to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module sell_slice_set_builder_unit
    import sssb_pkg::*;
#(
    parameter int MAX_COLUMNS     = DEF_MAX_COLUMNS,
    parameter int MAX_SLICE_ROWS  = DEF_MAX_SLICE_ROWS,
    parameter int ROW_QUEUE_DEPTH = DEF_ROW_QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [ELEM_W-1:0]    element_bits,
    input  wire logic                 row_end,
    input  wire logic                 matrix_end,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [NUM_W-1:0]          slice_number,
    output logic [LEN_W-1:0]          slice_length,
    output logic [OFS_W-1:0]          slice_start,
    output logic [OFS_W-1:0]          slice_end,
    output logic                      last_slice
);

    localparam int REC_W = $clog2(MAX_COLUMNS + 1) + 1;

    logic [CFG_W-1:0] slice_rows_reg;
    logic [CFG_W-1:0] slice_rows_next;
    logic [CFG_W-1:0] stride_reg;
    logic [CFG_W-1:0] stride_next;

    logic             q_push;
    logic [REC_W-1:0] q_push_data;
    logic             q_full;
    logic             q_pop;
    logic [REC_W-1:0] q_pop_data;
    logic             q_empty;

    // Decode configuration writes
    always_comb
    begin
        slice_rows_next = slice_rows_reg;
        stride_next     = stride_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SLICE_ROWS:   slice_rows_next = cfg_data;
                REG_ROUND_STRIDE: stride_next     = cfg_data;
                default:
                begin
                    slice_rows_next = slice_rows_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_rows_reg <= SLICE_ROWS_RESET;
            stride_reg     <= ROUND_STRIDE_RESET;
        end
        else
        begin
            slice_rows_reg <= slice_rows_next;
            stride_reg     <= stride_next;
        end
    end

    sssb_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .element_bits (element_bits),
        .row_end      (row_end),
        .matrix_end   (matrix_end),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    sssb_queue #(
        .WIDTH (REC_W),
        .DEPTH (ROW_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    sssb_back #(
        .MAX_COLUMNS    (MAX_COLUMNS),
        .MAX_SLICE_ROWS (MAX_SLICE_ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .slice_rows    (slice_rows_reg),
        .round_stride  (stride_reg),
        .q_empty       (q_empty),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slice_number  (slice_number),
        .slice_length  (slice_length),
        .slice_start   (slice_start),
        .slice_end     (slice_end),
        .last_slice    (last_slice)
    );

endmodule

`default_nettype wire

[verif/sell_slice_set_builder_unit_tb.sv]
// ----------------------------------------------------------------------------
// sell_slice_set_builder_unit_tb
// Streams dense matrices of double words into the slice set builder. A
// built-in predictor tracks row counts, slice peaks and offsets, and every
// slice word is checked field by field. The run covers directed corner cases
// (signed zero, NaN, matrix end mid-row, clamped registers, a size change
// mid-slice, row count saturation) and then randomized matrices under several
// register settings, with random bursts on the input and stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sell_slice_set_builder_unit_tb;
    import sssb_pkg::*;

    // Narrow column limit keeps the overlong row short
    localparam int MAX_COLUMNS    = 64;
    localparam int MAX_SLICE_ROWS = DEF_MAX_SLICE_ROWS;
    localparam int IDLE_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int PHASE_WORDS    = 30;
    localparam logic [ELEM_W-1:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

    typedef struct {
        logic [ELEM_W-1:0] bits;
        logic              row_last;
        logic              matrix_last;
    } element_word_t;

    typedef struct {
        logic [NUM_W-1:0] number;
        logic [LEN_W-1:0] length;
        logic [OFS_W-1:0] start_ofs;
        logic [OFS_W-1:0] end_ofs;
        logic             closes_matrix;
    } slice_record_t;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_PATTERN} stall_mode_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data     = '0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [ELEM_W-1:0] element_bits = '0;
    logic              row_end      = 1'b0;
    logic              matrix_end   = 1'b0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [NUM_W-1:0]  slice_number;
    logic [LEN_W-1:0]  slice_length;
    logic [OFS_W-1:0]  slice_start;
    logic [OFS_W-1:0]  slice_end;
    logic              last_slice;

    // Predictor copy of the registers and running state
    logic [CFG_W-1:0] size_setting   = SLICE_ROWS_RESET;
    logic [CFG_W-1:0] stride_setting = ROUND_STRIDE_RESET;
    int unsigned      row_count  = 0;
    int unsigned      rows_taken = 0;
    int unsigned      peak_len   = 0;
    logic [OFS_W-1:0] offset_acc = '0;
    logic [NUM_W-1:0] slice_idx  = '0;

    slice_record_t slices_due[$];
    element_word_t word_queue[$];
    int unsigned   words_pushed = 0;
    int unsigned   words_taken  = 0;
    int unsigned   slices_taken = 0;
    int unsigned   error_count  = 0;
    int unsigned   cycle_count  = 0;

    sell_slice_set_builder_unit #(
        .MAX_COLUMNS    (MAX_COLUMNS),
        .MAX_SLICE_ROWS (MAX_SLICE_ROWS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .element_bits (element_bits),
        .row_end      (row_end),
        .matrix_end   (matrix_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slice_number (slice_number),
        .slice_length (slice_length),
        .slice_start  (slice_start),
        .slice_end    (slice_end),
        .last_slice   (last_slice)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp the register values the way the block honors them
    function automatic int unsigned effective_rows(input logic [CFG_W-1:0] size);
        if (size == 0)
            return 1;
        if (size > MAX_SLICE_ROWS)
            return MAX_SLICE_ROWS;
        return size;
    endfunction

    function automatic int unsigned effective_stride(input logic [CFG_W-1:0] stride);
        if (stride == 0)
            return 1;
        if (stride > STRIDE_MAX)
            return STRIDE_MAX;
        return stride;
    endfunction

    // Count one element word and queue a slice record when a slice closes
    task automatic predict_slice(input element_word_t w);
        int unsigned   stride;
        int unsigned   rounded;
        logic [63:0]   stop;
        slice_record_t rec;
        if (w.bits[ELEM_W-2:0] != '0 && row_count < MAX_COLUMNS)
            row_count++;
        if (!w.row_last && !w.matrix_last)
            return;
        stride = effective_stride(stride_setting);
        rounded = ((row_count + stride - 1) / stride) * stride;
        if (rounded > peak_len)
            peak_len = rounded;
        row_count = 0;
        rows_taken++;
        if (rows_taken < effective_rows(size_setting) && !w.matrix_last)
            return;
        rec.number = slice_idx;
        rec.length = LEN_W'(peak_len);
        rec.start_ofs = offset_acc;
        stop = 64'(offset_acc) + 64'(rec.length);
        rec.end_ofs = (stop > 64'hFFFF_FFFF) ? '1 : stop[OFS_W-1:0];
        rec.closes_matrix = w.matrix_last;
        slices_due.push_back(rec);
        // Start over after a matrix, else advance to the next slice
        if (w.matrix_last) begin
            offset_acc = '0;
            slice_idx = '0;
        end
        else begin
            offset_acc = rec.end_ofs;
            slice_idx = slice_idx + 1'b1;
        end
        peak_len = 0;
        rows_taken = 0;
    endtask

    task automatic compare_field(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endtask

    // Sample both channels: predict on accepted input, check accepted output
    always @(posedge clk)
    begin : monitor
        element_word_t seen;
        slice_record_t due;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                seen.bits = element_bits;
                seen.row_last = row_end;
                seen.matrix_last = matrix_end;
                predict_slice(seen);
                words_taken++;
            end
            if (out_valid && !out_stall) begin
                slices_taken++;
                if (slices_due.size() == 0) begin
                    $error("unexpected slice word: slice_number %0d", slice_number);
                    error_count++;
                end
                else begin
                    due = slices_due.pop_front();
                    compare_field("slice_number", due.number, slice_number);
                    compare_field("slice_length", due.length, slice_length);
                    compare_field("slice_start", due.start_ofs, slice_start);
                    compare_field("slice_end", due.end_ofs, slice_end);
                    compare_field("last_slice", due.closes_matrix, last_slice);
                end
            end
        end
    end

    // Offer words in bursts with random gaps; hold the word while stalled
    always @(posedge clk)
    begin : driver
        element_word_t next_word;
        int unsigned   burst_left;
        int unsigned   gap_left;
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!in_valid || !in_stall) begin
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (word_queue.size() != 0) begin
                next_word = word_queue.pop_front();
                in_valid <= 1'b1;
                element_bits <= next_word.bits;
                row_end <= next_word.row_last;
                matrix_end <= next_word.matrix_last;
                if (burst_left != 0)
                    burst_left--;
                else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the output on a changing pattern, with long holds now and then
    always @(posedge clk)
    begin : receiver
        stall_mode_t mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned pattern_tick;
        bit          long_hold_done;
        if (!rst_n) begin
            out_stall <= 1'b0;
            mode = STALL_NONE;
            mode_left = 0;
            hold_left = 0;
            pattern_tick = 0;
            long_hold_done = 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if ((!long_hold_done && out_valid && effective_rows(size_setting) == 1 &&
                  word_queue.size() >= 12) ||
                 (out_valid && $urandom_range(0, 999) == 0)) begin
            hold_left = $urandom_range(300, 600);
            long_hold_done = 1'b1;
            out_stall <= 1'b1;
        end
        else begin
            if (mode_left == 0) begin
                mode = stall_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            else begin
                mode_left--;
            end
            pattern_tick++;
            case (mode)
                STALL_NONE:    out_stall <= 1'b0;
                STALL_COIN:    out_stall <= 1'($urandom_range(0, 1));
                STALL_PATTERN: out_stall <= (pattern_tick % 4 != 0);
                default:       out_stall <= 1'b0;
            endcase
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void push_word(input logic [ELEM_W-1:0] bits, input logic row_last,
                                      input logic matrix_last);
        element_word_t w;
        w.bits = bits;
        w.row_last = row_last;
        w.matrix_last = matrix_last;
        word_queue.push_back(w);
        words_pushed++;
    endfunction

    // Push a row of nonzero words, the last one ending the row
    function automatic void push_dense_row(input int unsigned count, input logic matrix_last);
        for (int unsigned c = 0; c < count; c++)
            push_word(ONE_BITS, c == count - 1, matrix_last && c == count - 1);
    endfunction

    // Often zeros of either sign, some denormals and NaNs, the rest anything
    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3:       return {1'b1, 63'b0};
            4:       return {12'b0, 20'($urandom), 32'($urandom)};
            5:       return {1'($urandom), 11'h7FF, 20'($urandom), 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Push a random matrix; the closing word may or may not mark a row end
    function automatic void add_matrix(input int unsigned rows, input int unsigned max_len);
        int unsigned len;
        bit          last_row;
        for (int unsigned r = 0; r < rows; r++) begin
            len = $urandom_range(1, max_len);
            last_row = (r == rows - 1);
            for (int unsigned c = 0; c < len; c++)
                push_word(random_element(),
                          (c == len - 1) && (!last_row || $urandom_range(0, 1)),
                          last_row && c == len - 1);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] size, input logic [CFG_W-1:0] stride);
        write_reg(REG_SLICE_ROWS, size);
        size_setting = size;
        write_reg(REG_ROUND_STRIDE, stride);
        stride_setting = stride;
    endtask

    // Wait until every word is taken and every slice has come back, then drain
    task automatic wait_idle();
        while (words_taken != words_pushed || slices_due.size() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] size,
                                    input logic [CFG_W-1:0] stride);
        int unsigned phase_start;
        int unsigned span;
        int unsigned rows;
        int unsigned max_len;
        set_config(size, stride);
        phase_start = words_pushed;
        span = effective_rows(size);
        while (words_pushed - phase_start < PHASE_WORDS) begin
            max_len = ($urandom_range(0, 4) == 0) ? 40 : 6;
            if (span <= 16 && $urandom_range(0, 2) == 0)
                rows = span * $urandom_range(1, 3);
            else
                rows = $urandom_range(1, 24);
            add_matrix(rows, max_len);
        end
        wait_idle();
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero tests, then matrix end on a non-row-end word
        push_word(64'h0000_0000_0000_0000, 1'b0, 1'b0);
        push_word(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        push_word(64'h7FF8_0000_0000_0000, 1'b0, 1'b0);
        push_word(64'h0000_0000_0000_0001, 1'b0, 1'b0);
        push_word(64'h7FF0_0000_0000_0000, 1'b0, 1'b0);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        push_word(64'h8000_0000_0000_0001, 1'b1, 1'b0);
        push_word(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        push_word(ONE_BITS, 1'b0, 1'b0);
        push_word(64'h0000_0000_0000_0000, 1'b0, 1'b1);
        wait_idle();

        // Zero registers act as one: one row per slice
        set_config(9'd0, 9'd0);
        push_dense_row(2, 1'b0);
        push_word(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        push_dense_row(2, 1'b1);
        wait_idle();

        // Registers above range clamp to the maximum
        set_config(9'd511, 9'd511);
        push_dense_row(3, 1'b0);
        push_word(64'h0000_0000_0000_0000, 1'b1, 1'b1);
        wait_idle();

        // Full slice at matrix end, then leave a slice open
        set_config(9'd2, 9'd3);
        push_dense_row(1, 1'b0);
        push_dense_row(2, 1'b0);
        push_dense_row(4, 1'b0);
        push_dense_row(1, 1'b1);
        push_dense_row(2, 1'b0);
        push_dense_row(5, 1'b0);
        push_dense_row(1, 1'b0);
        wait_idle();

        // Lower the slice size mid-slice: the next row end closes it
        set_config(9'd1, 9'd3);
        push_dense_row(2, 1'b0);
        push_dense_row(7, 1'b1);
        wait_idle();

        // Overlong row saturates its count; matrix end without row end
        set_config(9'd1, 9'd255);
        for (int i = 0; i < MAX_COLUMNS + 3; i++)
            push_word(ONE_BITS, 1'b0, 1'b0);
        push_word(ONE_BITS, 1'b0, 1'b1);
        wait_idle();

        // One-word rows back to back while the output holds off
        set_config(9'd1, 9'd1);
        for (int i = 0; i < 23; i++)
            push_dense_row(1, 1'b0);
        push_dense_row(1, 1'b1);
        wait_idle();

        // Random matrices under a spread of settings
        run_random_phase(9'd1, 9'd1);
        run_random_phase(9'd2, 9'd4);
        run_random_phase(9'd5, 9'd0);
        run_random_phase(9'd0, 9'd511);
        run_random_phase(9'd16, 9'd2);
        run_random_phase(9'd3, 9'd256);
        run_random_phase(9'd256, 9'd3);
        run_random_phase(9'd511, 9'd1);
        run_random_phase(9'd7, 9'd8);
        run_random_phase(9'($urandom_range(1, 300)), 9'($urandom_range(1, 300)));

        if (error_count == 0 && slices_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sell_slice_set_builder_unit.f]
+incdir+design
design/sssb_pkg.sv
design/sssb_front.sv
design/sssb_queue.sv
design/sssb_back.sv
design/sell_slice_set_builder_unit.sv
verif/sell_slice_set_builder_unit_tb.sv
